### rtl/ntt_montgomery_butterfly_macros.svh
// Assertion macros for the Montgomery butterfly block.
`ifndef NTT_MONTGOMERY_BUTTERFLY_MACROS_SVH
`define NTT_MONTGOMERY_BUTTERFLY_MACROS_SVH

`ifndef SYNTH
`define NTTMB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nttmb assertion failed");
`define NTTMB_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nttmb reset assertion failed");
`else
`define NTTMB_ASSERT(lbl, clk, rst_n, prop)
`define NTTMB_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

### rtl/nttmb_pkg.sv
// Package with widths, codes and shared types of the Montgomery butterfly.
package nttmb_pkg;

    localparam int VAL_W      = 14;
    localparam int NINV_W     = 16;
    localparam int OP_W       = 2;
    localparam int X_W        = VAL_W + 3;
    localparam int PROD_W     = 32;
    localparam int K_W        = VAL_W + NINV_W;
    localparam int R_W        = 16;
    localparam int S_W        = VAL_W + 5;
    localparam int PIPE_DEPTH = 7;
    localparam int CFG_IDX_W  = 1;

    localparam logic [VAL_W-1:0]  MODULUS_RST = 14'd12289;
    localparam logic [NINV_W-1:0] NINV_RST    = 16'd12287;

    typedef logic [VAL_W-1:0] t_val;

    typedef enum logic [OP_W-1:0] {
        OP_FWD   = 2'd0,
        OP_INV   = 2'd1,
        OP_SCALE = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS     = 1'b0,
        CFG_NEG_MOD_INV = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [VAL_W-1:0]  modulus;
        logic [NINV_W-1:0] neg_mod_inverse;
    } t_cfg;

    typedef struct packed {
        t_op  op;
        t_val a;
        t_val s_inv;
    } t_side;

    typedef logic [PIPE_DEPTH-1:0] t_stage_en;

endpackage

### rtl/nttmb_if.sv
// Channel interfaces for input items, result items and configuration writes.
interface nttmb_in_if import nttmb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] first_value;
    logic [VAL_W-1:0] second_value;
    logic [VAL_W-1:0] twiddle;

    modport source (output valid, op, first_value, second_value, twiddle, input ready);
    modport sink (input valid, op, first_value, second_value, twiddle, output ready);
endinterface

interface nttmb_out_if import nttmb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] sum_out;
    logic [VAL_W-1:0] diff_out;

    modport source (output valid, sum_out, diff_out, input ready);
    modport sink (input valid, sum_out, diff_out, output ready);
endinterface

interface nttmb_cfg_if import nttmb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [NINV_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/nttmb_pre.sv
// First stage: operand selection and the inverse butterfly modular add and subtract.
module nttmb_pre import nttmb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  t_cfg                  i_cfg,
    input  logic [OP_W-1:0]       i_op,
    input  t_val                  i_a,
    input  t_val                  i_b,
    input  t_val                  i_tw,
    output logic signed [X_W-1:0] o_x,
    output t_val                  o_y,
    output t_side                 o_side
);

    logic signed [X_W-1:0] n_ab;
    logic signed [X_W-1:0] n_xinv;
    logic signed [X_W-1:0] n_sab;
    logic signed [X_W-1:0] n_sinv;
    logic signed [X_W-1:0] n_x;
    logic signed [X_W-1:0] q_ext;
    logic signed [X_W-1:0] r_x;
    t_val                  r_y;
    t_side                 r_side;
    t_side                 n_side;

    always_comb begin
        q_ext  = $signed({3'b0, i_cfg.modulus});
        n_ab   = $signed({3'b0, i_a}) - $signed({3'b0, i_b});
        n_xinv = n_ab[X_W-1] ? n_ab + q_ext : n_ab;
        n_sab  = $signed({3'b0, i_a}) + $signed({3'b0, i_b}) - q_ext;
        n_sinv = n_sab[X_W-1] ? n_sab + q_ext : n_sab;
        case (t_op'(i_op))
            OP_FWD:  n_x = $signed({3'b0, i_b});
            OP_INV:  n_x = n_xinv;
            default: n_x = $signed({3'b0, i_a});
        endcase
        n_side.op    = t_op'(i_op);
        n_side.a     = i_a;
        n_side.s_inv = n_sinv[VAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= i_tw;
            r_side <= n_side;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_side = r_side;

endmodule

### rtl/nttmb_mont.sv
// Five-stage Montgomery multiplier with side data carried alongside.
module nttmb_mont import nttmb_pkg::*; (
    input  logic                  i_clk,
    input  logic [4:0]            i_en,
    input  t_cfg                  i_cfg,
    input  logic signed [X_W-1:0] i_x,
    input  t_val                  i_y,
    input  t_side                 i_side,
    output logic [R_W-1:0]        o_w,
    output t_side                 o_side
);

    logic signed [PROD_W-1:0] n_p;
    logic [PROD_W-1:0]        r_p1;
    logic [PROD_W-1:0]        r_p2;
    logic [PROD_W-1:0]        r_p3;
    logic [NINV_W-1:0]        n_m;
    logic [NINV_W-1:0]        r_m;
    logic [K_W-1:0]           n_k;
    logic [K_W-1:0]           r_k;
    logic [PROD_W-1:0]        n_sum;
    logic [R_W-1:0]           r_r;
    logic [R_W-1:0]           n_w;
    logic [R_W-1:0]           r_w;
    t_side                    r_side [5];

    always_comb begin
        n_p   = 32'(i_x) * $signed({18'b0, i_y});
        n_m   = 16'(r_p1[NINV_W-1:0] * i_cfg.neg_mod_inverse);
        n_k   = K_W'(r_m) * K_W'(i_cfg.modulus);
        n_sum = r_p3 + {2'b0, r_k};
        n_w   = (r_r >= {2'b0, i_cfg.modulus}) ? r_r - {2'b0, i_cfg.modulus} : r_r;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p1      <= n_p;
            r_side[0] <= i_side;
        end
        if (i_en[1]) begin
            r_m       <= n_m;
            r_p2      <= r_p1;
            r_side[1] <= r_side[0];
        end
        if (i_en[2]) begin
            r_k       <= n_k;
            r_p3      <= r_p2;
            r_side[2] <= r_side[1];
        end
        if (i_en[3]) begin
            r_r       <= n_sum[PROD_W-1:PROD_W-R_W];
            r_side[3] <= r_side[2];
        end
        if (i_en[4]) begin
            r_w       <= n_w;
            r_side[4] <= r_side[3];
        end
    end

    assign o_w    = r_w;
    assign o_side = r_side[4];

endmodule

### rtl/nttmb_post.sv
// Last stage: forward butterfly add and subtract and result selection.
module nttmb_post import nttmb_pkg::*; (
    input  logic           i_clk,
    input  logic           i_en,
    input  t_cfg           i_cfg,
    input  logic [R_W-1:0] i_w,
    input  t_side          i_side,
    output t_val           o_sum,
    output t_val           o_diff
);

    logic signed [S_W-1:0] q_ext;
    logic signed [S_W-1:0] n_fs;
    logic signed [S_W-1:0] n_fsum;
    logic signed [S_W-1:0] n_fd;
    logic signed [S_W-1:0] n_fdiff;
    t_val                  n_sum;
    t_val                  n_diff;
    t_val                  r_sum;
    t_val                  r_diff;

    always_comb begin
        q_ext   = $signed({5'b0, i_cfg.modulus});
        n_fs    = $signed({5'b0, i_side.a}) + $signed({3'b0, i_w}) - q_ext;
        n_fsum  = n_fs[S_W-1] ? n_fs + q_ext : n_fs;
        n_fd    = $signed({5'b0, i_side.a}) - $signed({3'b0, i_w});
        n_fdiff = n_fd[S_W-1] ? n_fd + q_ext : n_fd;
        case (i_side.op)
            OP_FWD: begin
                n_sum  = n_fsum[VAL_W-1:0];
                n_diff = n_fdiff[VAL_W-1:0];
            end
            OP_INV: begin
                n_sum  = i_side.s_inv;
                n_diff = i_w[VAL_W-1:0];
            end
            OP_SCALE: begin
                n_sum  = i_w[VAL_W-1:0];
                n_diff = '0;
            end
            default: begin
                n_sum  = '0;
                n_diff = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_diff <= n_diff;
        end
    end

    assign o_sum  = r_sum;
    assign o_diff = r_diff;

endmodule

### rtl/ntt_montgomery_butterfly.sv
// Montgomery butterfly for the number theoretic transform. Each input
// transaction produces exactly one result transaction, and a new transaction
// is taken every cycle unless an output stall has backed up into the first
// stage: the work runs through a seven-stage pipeline (operand preparation,
// three multiplier stages, the Montgomery sum, the final reduction and the
// butterfly output stage). Each stage holds its own valid bit and moves on
// whenever the stage after it is free, so a stall at the output only backs up
// the full stages and empty stages keep filling. Modulus and the negative
// modular inverse are written through the configuration channel, which is
// always ready; write them only while no transaction is in flight.
`include "ntt_montgomery_butterfly_macros.svh"

module ntt_montgomery_butterfly import nttmb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nttmb_in_if.sink     i_in,
    nttmb_out_if.source  o_out,
    nttmb_cfg_if.sink    i_cfg
);

    t_cfg                  r_cfg;
    t_stage_en             r_vld;
    t_stage_en             adv;
    logic signed [X_W-1:0] pre_x;
    t_val                  pre_y;
    t_side                 pre_side;
    logic [R_W-1:0]        mont_w;
    t_side                 mont_side;

    always_comb begin
        adv[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || o_out.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulus         <= MODULUS_RST;
            r_cfg.neg_mod_inverse <= NINV_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MODULUS:     r_cfg.modulus <= i_cfg.data[VAL_W-1:0];
                CFG_NEG_MOD_INV: r_cfg.neg_mod_inverse <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = adv[0];
    assign o_out.valid = r_vld[PIPE_DEPTH-1];

    nttmb_pre u_pre (
        .i_clk  (i_clk),
        .i_en   (adv[0]),
        .i_cfg  (r_cfg),
        .i_op   (i_in.op),
        .i_a    (i_in.first_value),
        .i_b    (i_in.second_value),
        .i_tw   (i_in.twiddle),
        .o_x    (pre_x),
        .o_y    (pre_y),
        .o_side (pre_side)
    );

    nttmb_mont u_mont (
        .i_clk  (i_clk),
        .i_en   (adv[5:1]),
        .i_cfg  (r_cfg),
        .i_x    (pre_x),
        .i_y    (pre_y),
        .i_side (pre_side),
        .o_w    (mont_w),
        .o_side (mont_side)
    );

    nttmb_post u_post (
        .i_clk  (i_clk),
        .i_en   (adv[6]),
        .i_cfg  (r_cfg),
        .i_w    (mont_w),
        .i_side (mont_side),
        .o_sum  (o_out.sum_out),
        .o_diff (o_out.diff_out)
    );

    `NTTMB_ASSERT(a_accept_fills_first, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> r_vld[0])
    `NTTMB_ASSERT(a_stall_holds_item, i_clk, i_rst_n, (r_vld[5] && !adv[6]) |=> r_vld[5])
    `NTTMB_ASSERT(a_item_reaches_out, i_clk, i_rst_n, (r_vld[5] && adv[6]) |=> r_vld[6])
    `NTTMB_ASSERT_NORST(a_reset_empties, i_clk, !i_rst_n |=> (r_vld == '0))

endmodule
